[src/mi_pkg.sv]
// Shared constants and types for the modular inverse block.
package mi_pkg;

  // Width of the value, modulus and inverse fields.
  localparam int VAL_W = 31;
  // Nominal coefficient width; one guard bit is added for shifted partial products.
  localparam int WIDTH = 32;
  localparam int COEF_W = WIDTH + 1;

  // Modulus after reset.
  localparam logic [VAL_W-1:0] MODULUS_RESET = {VAL_W{1'b1}};

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [COEF_W-1:0] coef_t;

  // One queued job: the value and whether it is trivially not invertible.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             trivial;
  } mi_item_t;

  // Handshake from the front queue to the back engine.
  typedef struct packed {
    logic     valid;
    mi_item_t item;
  } mi_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_FINISH
  } mi_state_t;

endpackage

[src/mi_front.sv]
// Input side: accepts values, flags trivial cases and queues them for the engine.
module mi_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [mi_pkg::VAL_W-1:0] in_value,
  output logic                     full,
  input  logic [mi_pkg::VAL_W-1:0] modulus,
  output mi_pkg::mi_job_t          job,
  input  logic                     job_ready
);

  mi_pkg::mi_item_t          mem_r [mi_pkg::FIFO_DEPTH];
  logic [mi_pkg::PTR_W-1:0]  wr_ptr_r;
  logic [mi_pkg::PTR_W-1:0]  rd_ptr_r;
  logic [mi_pkg::CNT_W-1:0]  count_r;
  logic                      wr_en;
  logic                      rd_en;
  mi_pkg::mi_item_t          wr_item;

  // A zero value or a modulus below two has no inverse at all.
  always_comb begin
    wr_item.value   = in_value;
    wr_item.trivial = (in_value == '0) || (modulus < mi_pkg::VAL_W'(2));
  end

  assign full      = (count_r == mi_pkg::CNT_W'(mi_pkg::FIFO_DEPTH));
  assign wr_en     = push && !full;
  assign job.valid = (count_r != '0);
  assign job.item  = mem_r[rd_ptr_r];
  assign rd_en     = job.valid && job_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[src/mi_back.sv]
// Extended Euclidean engine with shift-and-subtract division and a result register.
module mi_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [mi_pkg::VAL_W-1:0] modulus,
  input  mi_pkg::mi_job_t          job,
  output logic                     job_ready,
  output logic                     empty,
  input  logic                     pop,
  output logic [mi_pkg::VAL_W-1:0] out_inverse,
  output logic                     out_not_invertible
);

  mi_pkg::mi_state_t          state_r, state_nxt;
  logic [mi_pkg::VAL_W-1:0]   r_old_r, r_old_nxt;
  logic [mi_pkg::VAL_W-1:0]   r_new_r, r_new_nxt;
  logic [mi_pkg::VAL_W-1:0]   d_r, d_nxt;
  mi_pkg::coef_t              t_old_r, t_old_nxt;
  mi_pkg::coef_t              t_new_r, t_new_nxt;
  mi_pkg::coef_t              td_r, td_nxt;
  logic                       res_valid_r, res_valid_nxt;
  logic [mi_pkg::VAL_W-1:0]   res_inv_r, res_inv_nxt;
  logic                       res_bad_r, res_bad_nxt;

  logic                       sub_ok;
  logic [mi_pkg::VAL_W-1:0]   r_sub;
  mi_pkg::coef_t              t_sub;
  mi_pkg::coef_t              t_lift;

  assign empty              = !res_valid_r;
  assign out_inverse        = res_inv_r;
  assign out_not_invertible = res_bad_r;
  assign job_ready          = (state_r == mi_pkg::ST_IDLE) && !res_valid_r;

  // One quotient bit: subtract the aligned divisor and its coefficient when it fits.
  always_comb begin
    sub_ok = (r_old_r >= d_r);
    r_sub  = sub_ok ? (r_old_r - d_r) : r_old_r;
    t_sub  = sub_ok ? (t_old_r - td_r) : t_old_r;
    t_lift = (t_old_r < 0) ?
             (t_old_r + mi_pkg::coef_t'({2'b00, modulus})) : t_old_r;
  end

  // Sequencer: grow the divisor, then walk it back down one bit per cycle.
  always_comb begin
    state_nxt     = state_r;
    r_old_nxt     = r_old_r;
    r_new_nxt     = r_new_r;
    d_nxt         = d_r;
    t_old_nxt     = t_old_r;
    t_new_nxt     = t_new_r;
    td_nxt        = td_r;
    res_valid_nxt = res_valid_r && !pop;
    res_inv_nxt   = res_inv_r;
    res_bad_nxt   = res_bad_r;
    case (state_r)
      mi_pkg::ST_IDLE: begin
        if (job.valid && job_ready) begin
          if (job.item.trivial) begin
            res_valid_nxt = 1'b1;
            res_inv_nxt   = '0;
            res_bad_nxt   = 1'b1;
          end else begin
            r_old_nxt = modulus;
            r_new_nxt = job.item.value;
            d_nxt     = job.item.value;
            t_old_nxt = '0;
            t_new_nxt = mi_pkg::coef_t'(1);
            td_nxt    = mi_pkg::coef_t'(1);
            state_nxt = mi_pkg::ST_UP;
          end
        end
      end
      mi_pkg::ST_UP: begin
        if ({1'b0, r_old_r} >= {d_r, 1'b0}) begin
          d_nxt  = {d_r[mi_pkg::VAL_W-2:0], 1'b0};
          td_nxt = td_r <<< 1;
        end else begin
          state_nxt = mi_pkg::ST_DOWN;
        end
      end
      mi_pkg::ST_DOWN: begin
        if (d_r == r_new_r) begin
          // Last quotient bit: swap remainders and coefficients.
          r_old_nxt = r_new_r;
          r_new_nxt = r_sub;
          t_old_nxt = t_new_r;
          t_new_nxt = t_sub;
          d_nxt     = r_sub;
          td_nxt    = t_sub;
          state_nxt = (r_sub == '0) ? mi_pkg::ST_FINISH : mi_pkg::ST_UP;
        end else begin
          r_old_nxt = r_sub;
          t_old_nxt = t_sub;
          d_nxt     = d_r >> 1;
          td_nxt    = td_r >>> 1;
        end
      end
      mi_pkg::ST_FINISH: begin
        // The gcd must be one; a negative coefficient is lifted by the modulus.
        res_valid_nxt = 1'b1;
        if (r_old_r == mi_pkg::VAL_W'(1)) begin
          res_inv_nxt = t_lift[mi_pkg::VAL_W-1:0];
          res_bad_nxt = 1'b0;
        end else begin
          res_inv_nxt = '0;
          res_bad_nxt = 1'b1;
        end
        state_nxt = mi_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mi_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mi_pkg::ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    r_old_r   <= r_old_nxt;
    r_new_r   <= r_new_nxt;
    d_r       <= d_nxt;
    t_old_r   <= t_old_nxt;
    t_new_r   <= t_new_nxt;
    td_r      <= td_nxt;
    res_inv_r <= res_inv_nxt;
    res_bad_r <= res_bad_nxt;
  end

  // A failed inverse always reads as zero.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_bad_r) |-> (res_inv_r == '0))
    else $error("not-invertible result with nonzero inverse");

  // The divisor never drops below the current remainder while dividing.
  a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mi_pkg::ST_UP || state_r == mi_pkg::ST_DOWN) |->
    (d_r >= r_new_r && r_new_r != '0))
    else $error("divisor misaligned or zero during division");

  // An accepted job either starts the engine or produces a result at once.
  a_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (job.valid && job_ready) |=> (state_r != mi_pkg::ST_IDLE || res_valid_r))
    else $error("accepted job was dropped");

  // The engine only runs while the result register is free.
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mi_pkg::ST_IDLE) |-> !res_valid_r)
    else $error("engine running while a result waits");

endmodule

[src/modular_inverse.sv]
// The engine works on one item at a time and starts the next item only once the result is
// popped.
// A two-beat input queue accepts new items while the engine runs or a result waits.
// Reset (synchronous, rst_n low): queue and result empty, modulus = 2^31 - 1.
module modular_inverse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [mi_pkg::VAL_W-1:0] in_value,
  output logic                     full,
  output logic                     empty,
  input  logic                     pop,
  output logic [mi_pkg::VAL_W-1:0] out_inverse,
  output logic                     out_not_invertible,
  input  logic                     cfg_wr_en,
  input  logic [mi_pkg::VAL_W-1:0] cfg_wr_data
);

  logic [mi_pkg::VAL_W-1:0] modulus_r;
  mi_pkg::mi_job_t          job;
  logic                     job_ready;

  // Modulus configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mi_pkg::MODULUS_RESET;
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  mi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_value  (in_value),
    .full      (full),
    .modulus   (modulus_r),
    .job       (job),
    .job_ready (job_ready)
  );

  mi_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .modulus            (modulus_r),
    .job                (job),
    .job_ready          (job_ready),
    .empty              (empty),
    .pop                (pop),
    .out_inverse        (out_inverse),
    .out_not_invertible (out_not_invertible)
  );

endmodule

[tb/mi_inverse_checker.sv]
// Checker for the modular inverse block: predicts every inverse and compares each result beat.
module mi_inverse_checker
  import mi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             full,
  input  logic [VAL_W-1:0] in_value,
  input  logic             empty,
  input  logic             pop,
  input  logic [VAL_W-1:0] out_inverse,
  input  logic             out_not_invertible,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  output int               fail_count,
  output int               pending,
  output int               results_seen,
  output int               flagged_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result beat, with the operands kept for the error report.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] modulus;
    logic [VAL_W-1:0] inverse;
    logic             not_invertible;
  } inverse_beat_t;

  inverse_beat_t    inverse_q[$];
  logic [VAL_W-1:0] modulus_copy = MODULUS_RESET;
  int               mismatches = 0;
  int               reported = 0;
  int               beats_checked = 0;
  int               beats_flagged = 0;

  // Extended Euclid on 64-bit signed values; a negative coefficient is lifted by the modulus.
  function automatic inverse_beat_t euclid_inverse(input logic [VAL_W-1:0] value,
                                                   input logic [VAL_W-1:0] modulus);
    inverse_beat_t beat;
    longint        r_old, r_new, t_old, t_new, quot, rem, t_next;
    logic [VAL_W-1:0] reduced;
    beat.value          = value;
    beat.modulus        = modulus;
    beat.inverse        = '0;
    beat.not_invertible = 1'b1;
    if (modulus < 2) return beat;
    reduced = value % modulus;
    if (reduced == 0) return beat;
    r_old = longint'(modulus);
    r_new = longint'(reduced);
    t_old = 0;
    t_new = 1;
    while (r_new != 0) begin
      quot   = r_old / r_new;
      rem    = r_old % r_new;
      r_old  = r_new;
      r_new  = rem;
      t_next = t_old - quot * t_new;
      t_old  = t_new;
      t_new  = t_next;
    end
    // A gcd other than one means the value shares a factor with the modulus.
    if (r_old != 1) return beat;
    if (t_old < 0) t_old = t_old + longint'(modulus);
    beat.inverse        = t_old[VAL_W-1:0];
    beat.not_invertible = 1'b0;
    return beat;
  endfunction

  // Track the register, queue a prediction per input beat and check each result beat.
  always @(posedge clk) begin
    inverse_beat_t want;
    logic          bad_beat;
    if (!rst_n) begin
      modulus_copy = MODULUS_RESET;
      inverse_q.delete();
    end else begin
      if (push && !full) begin
        inverse_q.insert(inverse_q.size(), euclid_inverse(in_value, modulus_copy));
      end
      if (cfg_wr_en) modulus_copy = cfg_wr_data;
      if (pop && !empty) begin
        beats_checked++;
        if (out_not_invertible === 1'b1) beats_flagged++;
        if (inverse_q.size() == 0) begin
          mismatches++;
          if (reported < 30) begin
            $display("%0t ns: result beat with nothing expected: inverse %0d flag %0b",
                     $time, out_inverse, out_not_invertible);
            reported++;
          end
        end else begin
          want     = inverse_q.pop_front();
          bad_beat = 1'b0;
          if (out_inverse !== want.inverse) begin
            bad_beat = 1'b1;
            if (reported < 30) begin
              $display("%0t ns: inverse of %0d mod %0d: expected %0d, actual %0d",
                       $time, want.value, want.modulus, want.inverse, out_inverse);
              reported++;
            end
          end
          if (out_not_invertible !== want.not_invertible) begin
            bad_beat = 1'b1;
            if (reported < 30) begin
              $display("%0t ns: not_invertible of %0d mod %0d: expected %0b, actual %0b",
                       $time, want.value, want.modulus, want.not_invertible,
                       out_not_invertible);
              reported++;
            end
          end
          if (bad_beat) mismatches++;
        end
      end
    end
    // Outputs move after the edge so the stimulus side reads them without a race.
    fail_count   <= mismatches;
    pending      <= inverse_q.size();
    results_seen <= beats_checked;
    flagged_seen <= beats_flagged;
  end

endmodule

[tb/tb_modular_inverse.sv]
// Top of the modular inverse testbench: clock, reset, stimulus, receiver and verdict.
module tb_modular_inverse;
  import mi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES     = 9;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 1000;

  logic             clk;
  logic             rst_n;
  logic             push;
  logic [VAL_W-1:0] in_value;
  logic             full;
  logic             empty;
  logic             pop;
  logic [VAL_W-1:0] out_inverse;
  logic             out_not_invertible;
  logic             cfg_wr_en;
  logic [VAL_W-1:0] cfg_wr_data;

  int fail_count;
  int pending;
  int results_seen;
  int flagged_seen;

  int               quiet_cycles = 0;
  int               burst_left = 0;
  int               values_sent = 0;
  int               holds_done = 0;
  logic [VAL_W-1:0] modulus_now = MODULUS_RESET;

  // Modulus of each phase; the first phase runs on the reset value without a write.
  logic [VAL_W-1:0] phase_modulus [NUM_PHASES] = '{
    MODULUS_RESET, 31'd2, 31'd1000000, 31'd65521, 31'h40000000,
    31'd0, 31'd1, 31'h7FFFFFFE, 31'h7FFFFFFF
  };
  int phase_random [NUM_PHASES] = '{380, 100, 300, 250, 250, 10, 10, 280, 250};

  modular_inverse uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .in_value           (in_value),
    .full               (full),
    .empty              (empty),
    .pop                (pop),
    .out_inverse        (out_inverse),
    .out_not_invertible (out_not_invertible),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  mi_inverse_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_value           (in_value),
    .empty              (empty),
    .pop                (pop),
    .out_inverse        (out_inverse),
    .out_not_invertible (out_not_invertible),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_seen       (results_seen),
    .flagged_seen       (flagged_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random value with a mix of full-width, small, near-modulus and shared-factor picks.
  function automatic logic [VAL_W-1:0] pick_value(input logic [VAL_W-1:0] m);
    longint unsigned mm, v;
    mm = m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4:          v = $urandom_range(0, 64);
      5: begin
        v = mm + $urandom_range(0, 6);
        v = (v >= 3) ? v - 3 : v;
      end
      6:          v = longint'($urandom_range(1, 20'hFFFFF)) * (2 + $urandom_range(0, 5));
      7:          v = (mm > 0) ? $urandom % mm : $urandom;
      8:          v = mm * $urandom_range(0, 4);
      default:    v = $urandom >> $urandom_range(1, 30);
    endcase
    return v[VAL_W-1:0];
  endfunction

  // Offer one beat; the sender idles between bursts of random length.
  task automatic send_value(input logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 20);
    end
    push     <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    values_sent++;
  endtask

  // Wait until every predicted result has been popped.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [VAL_W-1:0] m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    modulus_now = m;
  endtask

  // Stimulus: directed values first in some phases, then random values per modulus.
  initial begin
    logic [VAL_W-1:0] directed_list[$];
    push        <= 1'b0;
    in_value    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        push <= 1'b0;
        wait_drained();
        write_modulus(phase_modulus[p]);
      end
      case (p)
        // Prime modulus: zero, one, the modulus itself and wide bit patterns.
        0: directed_list = {31'd0, 31'd1, 31'd2, 31'h7FFFFFFF, 31'h7FFFFFFE,
                            31'h40000000, 31'h55555555, 31'h2AAAAAAA};
        // Composite modulus: shared factors, multiples and values above the modulus.
        2: directed_list = {31'd0, 31'd2, 31'd5, 31'd7, 31'd999999, 31'd1000000,
                            31'd1000001, 31'h7FFFFFFF};
        // Degenerate moduli zero and one.
        5, 6: directed_list = {31'd0, 31'd1, 31'h7FFFFFFF};
        default: directed_list = {};
      endcase
      foreach (directed_list[i]) send_value(directed_list[i]);
      repeat (phase_random[p]) send_value(pick_value(modulus_now));
    end

    push <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d values over %0d modulus settings, 0, 1, 2 and 2^31-1 included.",
             values_sent, NUM_PHASES);
    $display("%0d results checked, %0d not invertible, %0d long receiver hold-offs.",
             results_seen, flagged_seen, holds_done);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: stretches of steady, sparse or dense popping, plus two long hold-offs.
  initial begin
    int mode;
    int stretch;
    int hold_mark [2];
    hold_mark = '{150, 900};
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= hold_mark[holds_done]) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(10, 80);
        repeat (stretch) begin
          case (mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: too many cycles without any accepted beat ends the run.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles with %0d results pending.",
               quiet_cycles, pending);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
